>>> rtl/bma_pkg.sv
`timescale 1ns / 1ps

package bma_pkg;

    // pool geometry: 1024 units, ten levels below the root
    localparam int unsigned POOL_LEVELS = 10;
    localparam int unsigned POOL_UNITS  = 1 << POOL_LEVELS;
    localparam int unsigned NODE_COUNT  = 2 * POOL_UNITS - 1;
    localparam int unsigned NODE_AW     = $clog2(NODE_COUNT);
    localparam int unsigned SLF_W       = 4;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    // opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ABSENT = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_USED   = 2'd2,
        KIND_SPLIT  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [SLF_W-1:0]   slf;
    } node_t;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [NODE_AW-1:0] addr;
        node_t              wdata;
    } mem_req_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_ROOT,
        S_D_CHK,
        S_D_SPLR,
        S_D_L,
        S_F_CHK,
        S_UP_RD,
        S_UP_WR,
        S_FIN
    } state_t;

endpackage

>>> rtl/bma_node_ram.sv
`timescale 1ns / 1ps

module bma_node_ram
    import bma_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output node_t    rdata
);

    node_t mem [0:NODE_COUNT-1];
    node_t rdata_reg;

    // single port, registered read data held between reads
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bma_ctrl.sv
`timescale 1ns / 1ps

module bma_ctrl
    import bma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [10:0] request_size,
    input  logic [9:0]  free_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [9:0]  block_offset,
    output logic [10:0] grant_size,
    output mem_req_t    mreq,
    input  node_t       rdata
);

    state_t             state_reg, state_next;
    logic               op_reg, op_next;
    logic [SLF_W-1:0]   needk_reg, needk_next;
    logic [NODE_AW-1:0] idx_reg, idx_next;
    logic [SLF_W-1:0]   klev_reg, klev_next;
    logic [9:0]         off_reg, off_next;
    logic [9:0]         fo_reg, fo_next;
    node_t              cur_reg, cur_next;
    logic               use_cur_reg, use_cur_next;
    logic [SLF_W-1:0]   cslf_reg, cslf_next;
    logic               cfree_reg, cfree_next;
    logic [1:0]         rst_reg, rst_next;
    logic [9:0]         roff_reg, roff_next;
    logic [10:0]        rsize_reg, rsize_next;
    logic               ov_reg, ov_next;
    logic [1:0]         ost_reg, ost_next;
    logic [9:0]         ooff_reg, ooff_next;
    logic [10:0]        osize_reg, osize_next;

    logic [SLF_W-1:0]   req_k;
    node_t              node;
    logic [NODE_AW-1:0] lidx, ridx, sib, par;
    logic [SLF_W-1:0]   mx;
    logic               bit_r;

    // ceiling log2 of the request, zero counts as one unit
    always_comb
    begin
        req_k = '0;
        for (int k = 0; k <= POOL_LEVELS; k++)
        begin
            if ((11'd1 << k) < request_size)
            begin
                req_k = SLF_W'(k + 1);
            end
        end
    end

    // tree index helpers
    always_comb
    begin
        node  = use_cur_reg ? cur_reg : rdata;
        lidx  = {idx_reg[NODE_AW-2:0], 1'b1};
        ridx  = {idx_reg[NODE_AW-2:0], 1'b0} + NODE_AW'(2);
        sib   = idx_reg[0] ? idx_reg + NODE_AW'(1) : idx_reg - NODE_AW'(1);
        par   = (idx_reg - NODE_AW'(1)) >> 1;
        mx    = (cslf_reg > rdata.slf) ? cslf_reg : rdata.slf;
        bit_r = fo_reg[klev_reg[3:0] - 4'd1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        needk_reg   <= needk_next;
        idx_reg     <= idx_next;
        klev_reg    <= klev_next;
        off_reg     <= off_next;
        fo_reg      <= fo_next;
        cur_reg     <= cur_next;
        use_cur_reg <= use_cur_next;
        cslf_reg    <= cslf_next;
        cfree_reg   <= cfree_next;
        rst_reg     <= rst_next;
        roff_reg    <= roff_next;
        rsize_reg   <= rsize_next;
        ost_reg     <= ost_next;
        ooff_reg    <= ooff_next;
        osize_reg   <= osize_next;
    end

    // sequencer: descent, leaf update, then walk back to the root; refusals go straight to the result
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        needk_next   = needk_reg;
        idx_next     = idx_reg;
        klev_next    = klev_reg;
        off_next     = off_reg;
        fo_next      = fo_reg;
        cur_next     = cur_reg;
        use_cur_next = use_cur_reg;
        cslf_next    = cslf_reg;
        cfree_next   = cfree_reg;
        rst_next     = rst_reg;
        roff_next    = roff_reg;
        rsize_next   = rsize_reg;
        ov_next      = ov_reg;
        ost_next     = ost_reg;
        ooff_next    = ooff_reg;
        osize_next   = osize_reg;
        mreq         = '0;

        // result taken downstream
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                mreq.we         = 1'b1;
                mreq.addr       = '0;
                mreq.wdata.kind = KIND_FREE;
                mreq.wdata.slf  = SLF_W'(POOL_LEVELS + 1);
                state_next      = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = opcode;
                    needk_next   = req_k;
                    fo_next      = free_offset;
                    idx_next     = '0;
                    klev_next    = SLF_W'(POOL_LEVELS);
                    off_next     = '0;
                    use_cur_next = 1'b0;
                    if (opcode == OP_ALLOC && request_size > 11'(POOL_UNITS))
                    begin
                        rst_next   = ST_NOSPACE;
                        roff_next  = '0;
                        rsize_next = '0;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        mreq.re    = 1'b1;
                        mreq.addr  = '0;
                        state_next = (opcode == OP_ALLOC) ? S_A_ROOT : S_F_CHK;
                    end
                end
            end
            S_A_ROOT:
            begin
                if (rdata.slf < needk_reg + SLF_W'(1))
                begin
                    rst_next   = ST_NOSPACE;
                    roff_next  = '0;
                    rsize_next = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_D_CHK;
                end
            end
            S_D_CHK:
            begin
                if (klev_reg == needk_reg)
                begin
                    mreq.we         = 1'b1;
                    mreq.addr       = idx_reg;
                    mreq.wdata.kind = KIND_USED;
                    mreq.wdata.slf  = '0;
                    cslf_next       = '0;
                    cfree_next      = 1'b0;
                    rst_next        = ST_OK;
                    roff_next       = off_reg;
                    rsize_next      = 11'd1 << needk_reg;
                    state_next      = (idx_reg == '0) ? S_FIN : S_UP_RD;
                end
                else if (node.kind == KIND_FREE)
                begin
                    mreq.we         = 1'b1;
                    mreq.addr       = idx_reg;
                    mreq.wdata.kind = KIND_SPLIT;
                    mreq.wdata.slf  = node.slf;
                    state_next      = S_D_SPLR;
                end
                else
                begin
                    mreq.re    = 1'b1;
                    mreq.addr  = lidx;
                    state_next = S_D_L;
                end
            end
            S_D_SPLR:
            begin
                // right half becomes a free leaf, keep descending left
                mreq.we         = 1'b1;
                mreq.addr       = ridx;
                mreq.wdata.kind = KIND_FREE;
                mreq.wdata.slf  = klev_reg;
                cur_next.kind   = KIND_FREE;
                cur_next.slf    = klev_reg;
                use_cur_next    = 1'b1;
                idx_next        = lidx;
                klev_next       = klev_reg - SLF_W'(1);
                state_next      = S_D_CHK;
            end
            S_D_L:
            begin
                use_cur_next = 1'b0;
                klev_next    = klev_reg - SLF_W'(1);
                if (rdata.slf >= needk_reg + SLF_W'(1))
                begin
                    idx_next = lidx;
                end
                else
                begin
                    mreq.re   = 1'b1;
                    mreq.addr = ridx;
                    idx_next  = ridx;
                    off_next  = off_reg + (10'd1 << (klev_reg - SLF_W'(1)));
                end
                state_next = S_D_CHK;
            end
            S_F_CHK:
            begin
                if (rdata.kind == KIND_SPLIT && klev_reg != '0)
                begin
                    mreq.re   = 1'b1;
                    klev_next = klev_reg - SLF_W'(1);
                    if (bit_r)
                    begin
                        mreq.addr = ridx;
                        idx_next  = ridx;
                        off_next  = off_reg + (10'd1 << (klev_reg - SLF_W'(1)));
                    end
                    else
                    begin
                        mreq.addr = lidx;
                        idx_next  = lidx;
                    end
                end
                else if (rdata.kind == KIND_USED && off_reg == fo_reg)
                begin
                    mreq.we         = 1'b1;
                    mreq.addr       = idx_reg;
                    mreq.wdata.kind = KIND_FREE;
                    mreq.wdata.slf  = klev_reg + SLF_W'(1);
                    cslf_next       = klev_reg + SLF_W'(1);
                    cfree_next      = 1'b1;
                    rst_next        = ST_OK;
                    roff_next       = fo_reg;
                    rsize_next      = 11'd1 << klev_reg;
                    state_next      = (idx_reg == '0) ? S_FIN : S_UP_RD;
                end
                else
                begin
                    rst_next   = ST_BADFREE;
                    roff_next  = '0;
                    rsize_next = '0;
                    state_next = S_FIN;
                end
            end
            S_UP_RD:
            begin
                mreq.re    = 1'b1;
                mreq.addr  = sib;
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                mreq.we   = 1'b1;
                mreq.addr = par;
                // merge buddies on a free when both halves are free leaves
                if (op_reg == OP_FREE && cfree_reg && rdata.kind == KIND_FREE)
                begin
                    mreq.wdata.kind = KIND_FREE;
                    mreq.wdata.slf  = klev_reg + SLF_W'(2);
                    cslf_next       = klev_reg + SLF_W'(2);
                    cfree_next      = 1'b1;
                end
                else
                begin
                    mreq.wdata.kind = KIND_SPLIT;
                    mreq.wdata.slf  = mx;
                    cslf_next       = mx;
                    cfree_next      = 1'b0;
                end
                klev_next  = klev_reg + SLF_W'(1);
                idx_next   = par;
                state_next = (par == '0) ? S_FIN : S_UP_RD;
            end
            S_FIN:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ost_next   = rst_reg;
                    ooff_next  = roff_reg;
                    osize_next = rsize_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = ov_reg;
    assign status       = ost_reg;
    assign block_offset = ooff_reg;
    assign grant_size   = osize_reg;

endmodule

>>> rtl/buddy_memory_allocator_core.sv
`timescale 1ns / 1ps
// binary buddy allocator over a 1024-unit pool, tree state in one node memory
// the tree walk runs level by level down and back up through the single-port node memory
// throughput: one request at a time, the next accepted once the result is registered
// reset: the first state after reset writes the root as a free block; input stalls meanwhile

module buddy_memory_allocator_core
    import bma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [10:0] request_size,
    input  logic [9:0]  free_offset,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [9:0]  block_offset,
    output logic [10:0] grant_size
);

    mem_req_t mreq;
    node_t    rdata;

    // sequencer
    bma_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .request_size (request_size),
        .free_offset  (free_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .block_offset (block_offset),
        .grant_size   (grant_size),
        .mreq         (mreq),
        .rdata        (rdata)
    );

    // tree node memory
    bma_node_ram u_ram (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb
    import bma_pkg::*;
();

    localparam int NUM_RANDOM = 1100;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [10:0] request_size;
    logic [9:0]  free_offset;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [9:0]  block_offset;
    logic [10:0] grant_size;

    typedef struct packed {
        logic        op;
        logic [10:0] req;
        logic [9:0]  fo;
    } request_t;

    typedef struct packed {
        logic [1:0]  st;
        logic [9:0]  off;
        logic [10:0] size;
    } grant_t;

    request_t pending_reqs[$];
    grant_t   expected_grants[$];
    int       error_count;
    bit       quiet_phase;
    bit       hold_sender;

    // predictor copy of the buddy tree
    kind_t      tree_kind[NODE_COUNT];
    logic [3:0] tree_slf[NODE_COUNT];
    // blocks currently granted, for building valid frees
    int         live_offsets[$];

    buddy_memory_allocator_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .request_size (request_size),
        .free_offset  (free_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .block_offset (block_offset),
        .grant_size   (grant_size)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [3:0] larger(logic [3:0] a, logic [3:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic void tree_reset();
        for (int n = 0; n < NODE_COUNT; n++)
        begin
            tree_kind[n] = KIND_ABSENT;
            tree_slf[n]  = '0;
        end
        tree_kind[0] = KIND_FREE;
        tree_slf[0]  = 4'(POOL_LEVELS + 1);
    endfunction

    function automatic grant_t tree_alloc(int unsigned req);
        int unsigned need_lvl;
        int unsigned n;
        int unsigned lvl;
        int unsigned off;
        int unsigned l;
        int unsigned r;
        need_lvl = 0;
        n = 0;
        lvl = POOL_LEVELS;
        off = 0;
        if (req > POOL_UNITS)
            return '{ST_NOSPACE, 10'd0, 11'd0};
        while ((1 << need_lvl) < req)
            need_lvl++;
        if (tree_slf[0] < need_lvl + 1)
            return '{ST_NOSPACE, 10'd0, 11'd0};
        // walk down, splitting free blocks on the way
        while (lvl > need_lvl)
        begin
            l = 2 * n + 1;
            r = 2 * n + 2;
            if (tree_kind[n] == KIND_FREE)
            begin
                tree_kind[n] = KIND_SPLIT;
                tree_kind[l] = KIND_FREE;
                tree_kind[r] = KIND_FREE;
                tree_slf[l]  = 4'(lvl);
                tree_slf[r]  = 4'(lvl);
            end
            lvl--;
            if (tree_slf[l] >= need_lvl + 1)
                n = l;
            else
            begin
                n = r;
                off += 1 << lvl;
            end
        end
        tree_kind[n] = KIND_USED;
        tree_slf[n]  = '0;
        // walk back up refreshing largest-free
        while (n > 0)
        begin
            n = (n - 1) / 2;
            tree_slf[n] = larger(tree_slf[2 * n + 1], tree_slf[2 * n + 2]);
        end
        return '{ST_OK, 10'(off), 11'(1 << need_lvl)};
    endfunction

    function automatic grant_t tree_free(int unsigned fo);
        int unsigned n;
        int unsigned lvl;
        int unsigned off;
        int unsigned half;
        int unsigned size;
        int unsigned l;
        int unsigned r;
        n = 0;
        lvl = POOL_LEVELS;
        off = 0;
        if (fo >= POOL_UNITS)
            return '{ST_BADFREE, 10'd0, 11'd0};
        while (tree_kind[n] == KIND_SPLIT && lvl > 0)
        begin
            half = 1 << (lvl - 1);
            if (fo >= off + half)
            begin
                n = 2 * n + 2;
                off += half;
            end
            else
                n = 2 * n + 1;
            lvl--;
        end
        if (tree_kind[n] != KIND_USED || off != fo)
            return '{ST_BADFREE, 10'd0, 11'd0};
        size = 1 << lvl;
        tree_kind[n] = KIND_FREE;
        tree_slf[n]  = 4'(lvl + 1);
        // merge upward while both halves are free leaves
        while (n > 0)
        begin
            n = (n - 1) / 2;
            l = 2 * n + 1;
            r = 2 * n + 2;
            lvl++;
            if (tree_kind[l] == KIND_FREE && tree_kind[r] == KIND_FREE)
            begin
                tree_kind[n] = KIND_FREE;
                tree_kind[l] = KIND_ABSENT;
                tree_kind[r] = KIND_ABSENT;
                tree_slf[l]  = '0;
                tree_slf[r]  = '0;
                tree_slf[n]  = 4'(lvl + 1);
            end
            else
                tree_slf[n] = larger(tree_slf[l], tree_slf[r]);
        end
        return '{ST_OK, 10'(fo), 11'(size)};
    endfunction

    // queue a request and record its expected grant
    task automatic push_request(logic op, logic [10:0] req, logic [9:0] fo);
        grant_t g;
        int idx[$];
        if (op == OP_ALLOC)
        begin
            g = tree_alloc(req);
            if (g.st == ST_OK)
                live_offsets.push_back(g.off);
        end
        else
        begin
            g = tree_free(fo);
            if (g.st == ST_OK)
            begin
                idx = live_offsets.find_first_index(x) with (x == fo);
                if (idx.size() > 0)
                    live_offsets.delete(idx[0]);
            end
        end
        pending_reqs.push_back('{op, req, fo});
        expected_grants.push_back(g);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [10:0] random_size();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
            return 11'($urandom_range(0, 8));
        else if (sel < 85)
            return 11'($urandom_range(0, 64));
        else if (sel < 97)
            return 11'($urandom_range(0, 1024));
        return 11'($urandom_range(1025, 2047));
    endfunction

    // driver
    int unsigned send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            opcode       <= 1'b0;
            request_size <= '0;
            free_offset  <= '0;
            send_gap     <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                send_gap <= $urandom_range(0, 3);
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0 && !hold_sender)
            begin
                request_t q;
                q = pending_reqs.pop_front();
                in_valid     <= 1'b1;
                opcode       <= q.op;
                request_size <= q.req;
                free_offset  <= q.fo;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor and result-side stall
    int unsigned stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_grants.size() == 0)
                    report_mismatch("unexpected transfer status", status, -1);
                else
                begin
                    grant_t g;
                    g = expected_grants.pop_front();
                    if (status !== g.st)
                        report_mismatch("status", status, g.st);
                    if (block_offset !== g.off)
                        report_mismatch("block_offset", block_offset, g.off);
                    if (grant_size !== g.size)
                        report_mismatch("grant_size", grant_size, g.size);
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
            begin
                stall_left <= $urandom_range(0, 3);
                out_stall  <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // stimulus
    initial
    begin
        int unsigned sel;
        error_count = 0;
        quiet_phase = 1'b0;
        hold_sender = 1'b0;
        tree_reset();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes and special cases
        push_request(OP_FREE,  11'd0,    10'd0);     // free of never-allocated space
        push_request(OP_ALLOC, 11'd0,    10'd1023);  // zero size gets one unit
        push_request(OP_ALLOC, 11'd1024, 10'd0);     // too big for what is left
        push_request(OP_FREE,  11'd2047, 10'd0);
        push_request(OP_ALLOC, 11'd1024, 10'd0);     // whole pool
        push_request(OP_ALLOC, 11'd1,    10'd0);     // no space
        push_request(OP_FREE,  11'd0,    10'd512);   // inside a block
        push_request(OP_FREE,  11'd0,    10'd0);
        push_request(OP_ALLOC, 11'd2047, 10'd0);     // beyond the pool
        push_request(OP_ALLOC, 11'd1025, 10'd0);
        push_request(OP_ALLOC, 11'd3,    10'd0);
        push_request(OP_ALLOC, 11'd1,    10'd0);
        push_request(OP_ALLOC, 11'd513,  10'd0);
        push_request(OP_ALLOC, 11'd512,  10'd0);
        push_request(OP_FREE,  11'd0,    10'd4);
        push_request(OP_FREE,  11'd0,    10'd1023);
        push_request(OP_FREE,  11'd0,    10'd4);     // double free
        push_request(OP_FREE,  11'd0,    10'd0);
        push_request(OP_FREE,  11'd0,    10'd512);
        push_request(OP_ALLOC, 11'd1024, 10'd0);     // after merging back

        // wait until the tree has drained, then hold the sender
        wait (pending_reqs.size() == 0 && expected_grants.size() == 0);
        hold_sender = 1'b1;
        repeat (20) @(posedge clk);
        hold_sender = 1'b0;

        // random: allocs, valid frees of live blocks, some noise
        for (int k = 0; k < NUM_RANDOM; k++)
        begin
            if (k == NUM_RANDOM - 150)
                quiet_phase = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 45)
                push_request(OP_ALLOC, random_size(), 10'($urandom));
            else if (sel < 85 && live_offsets.size() > 0)
                push_request(OP_FREE, 11'($urandom),
                             10'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]));
            else
                push_request(OP_FREE, 11'($urandom), 10'($urandom));
            if (pending_reqs.size() > 8)
                wait (pending_reqs.size() <= 4);
        end

        wait (pending_reqs.size() == 0 && expected_grants.size() == 0);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule

>>> buddy_memory_allocator_core.f
rtl/bma_pkg.sv
rtl/bma_node_ram.sv
rtl/bma_ctrl.sv
rtl/buddy_memory_allocator_core.sv
tb/tb.sv
